// File: src/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg: shared types, codes and microprogram for the exponential search
// Holds the word formats of both channels, the control word layout and the
// read-only microprogram that steps the datapath through a search.
// ----------------------------------------------------------------------------
package eps_pkg;

  // Input word kinds.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  localparam int VALUE_W = 31;
  localparam int CMP_W   = 8;
  localparam int STEP_W  = 5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic             present;
    logic [CMP_W-1:0] comparisons;
  } result_t;

  // Datapath operations driven by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_CLEAR,
    OP_APPEND,
    OP_START,
    OP_READ,
    OP_DOUBLE,
    OP_FOUND,
    OP_SCAN_GT,
    OP_SCAN_END,
    OP_INC,
    OP_EMIT
  } op_t;

  // Jump conditions; when the condition holds the step counter loads the
  // target, otherwise it advances by one.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_KIND_CLEAR,
    C_KIND_APPEND,
    C_NOT_SEARCH,
    C_EMPTY,
    C_EQ,
    C_GT,
    C_PTR_GE_N,
    C_PTR_GT_HI,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic kind_clear;
    logic kind_append;
    logic kind_search;
    logic empty;
    logic eq;
    logic gt;
    logic ptr_ge_n;
    logic ptr_gt_hi;
    logic out_busy;
  } flags_t;

  // Step addresses of the microprogram.
  localparam logic [STEP_W-1:0] S_FETCH     = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP_CLR  = 5'd1;
  localparam logic [STEP_W-1:0] S_DISP_APP  = 5'd2;
  localparam logic [STEP_W-1:0] S_START     = 5'd3;
  localparam logic [STEP_W-1:0] S_EMPTY     = 5'd4;
  localparam logic [STEP_W-1:0] S_PROBE_RD  = 5'd5;
  localparam logic [STEP_W-1:0] S_PROBE_EQ  = 5'd6;
  localparam logic [STEP_W-1:0] S_PROBE_GT  = 5'd7;
  localparam logic [STEP_W-1:0] S_DOUBLE    = 5'd8;
  localparam logic [STEP_W-1:0] S_PAST_END  = 5'd9;
  localparam logic [STEP_W-1:0] S_LOOP      = 5'd10;
  localparam logic [STEP_W-1:0] S_FOUND     = 5'd11;
  localparam logic [STEP_W-1:0] S_GT_SETUP  = 5'd12;
  localparam logic [STEP_W-1:0] S_END_SETUP = 5'd13;
  localparam logic [STEP_W-1:0] S_SCAN_CHK  = 5'd14;
  localparam logic [STEP_W-1:0] S_SCAN_RD   = 5'd15;
  localparam logic [STEP_W-1:0] S_SCAN_EQ   = 5'd16;
  localparam logic [STEP_W-1:0] S_SCAN_INC  = 5'd17;
  localparam logic [STEP_W-1:0] S_EMIT      = 5'd18;
  localparam logic [STEP_W-1:0] S_RETURN    = 5'd19;
  localparam logic [STEP_W-1:0] S_CLEAR     = 5'd20;
  localparam logic [STEP_W-1:0] S_APPEND    = 5'd21;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
    case (step)
      S_FETCH:     w = '{op: OP_FETCH,    cond: C_NO_ACCEPT,   target: S_FETCH};
      S_DISP_CLR:  w = '{op: OP_NOP,      cond: C_KIND_CLEAR,  target: S_CLEAR};
      S_DISP_APP:  w = '{op: OP_NOP,      cond: C_KIND_APPEND, target: S_APPEND};
      S_START:     w = '{op: OP_START,    cond: C_NOT_SEARCH,  target: S_FETCH};
      S_EMPTY:     w = '{op: OP_NOP,      cond: C_EMPTY,       target: S_EMIT};
      S_PROBE_RD:  w = '{op: OP_READ,     cond: C_NEXT,        target: S_FETCH};
      S_PROBE_EQ:  w = '{op: OP_NOP,      cond: C_EQ,          target: S_FOUND};
      S_PROBE_GT:  w = '{op: OP_NOP,      cond: C_GT,          target: S_GT_SETUP};
      S_DOUBLE:    w = '{op: OP_DOUBLE,   cond: C_NEXT,        target: S_FETCH};
      S_PAST_END:  w = '{op: OP_NOP,      cond: C_PTR_GE_N,    target: S_END_SETUP};
      S_LOOP:      w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_PROBE_RD};
      S_FOUND:     w = '{op: OP_FOUND,    cond: C_ALWAYS,      target: S_EMIT};
      S_GT_SETUP:  w = '{op: OP_SCAN_GT,  cond: C_ALWAYS,      target: S_SCAN_CHK};
      S_END_SETUP: w = '{op: OP_SCAN_END, cond: C_NEXT,        target: S_FETCH};
      S_SCAN_CHK:  w = '{op: OP_NOP,      cond: C_PTR_GT_HI,   target: S_EMIT};
      S_SCAN_RD:   w = '{op: OP_READ,     cond: C_NEXT,        target: S_FETCH};
      S_SCAN_EQ:   w = '{op: OP_NOP,      cond: C_EQ,          target: S_FOUND};
      S_SCAN_INC:  w = '{op: OP_INC,      cond: C_ALWAYS,      target: S_SCAN_CHK};
      S_EMIT:      w = '{op: OP_EMIT,     cond: C_OUT_BUSY,    target: S_EMIT};
      S_RETURN:    w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_FETCH};
      S_CLEAR:     w = '{op: OP_CLEAR,    cond: C_ALWAYS,      target: S_FETCH};
      S_APPEND:    w = '{op: OP_APPEND,   cond: C_ALWAYS,      target: S_FETCH};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: src/eps_sequencer.sv
// ----------------------------------------------------------------------------
// eps_sequencer: microprogram step counter
// Fetches one control word per cycle from the microprogram table and
// resolves its conditional jump against the datapath flags.
// ----------------------------------------------------------------------------
module eps_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  eps_pkg::flags_t flags,
  output eps_pkg::ctrl_t  ctrl
);

  logic [eps_pkg::STEP_W-1:0] upc;
  logic [eps_pkg::STEP_W-1:0] upc_next;
  eps_pkg::uword_t            uword;
  logic                       take;

  assign uword   = eps_pkg::ucode_rom(upc);
  assign ctrl.op = uword.op;

  always_comb begin
    unique case (uword.cond)
      eps_pkg::C_NEXT:        take = 1'b0;
      eps_pkg::C_ALWAYS:      take = 1'b1;
      eps_pkg::C_NO_ACCEPT:   take = !flags.accept;
      eps_pkg::C_KIND_CLEAR:  take = flags.kind_clear;
      eps_pkg::C_KIND_APPEND: take = flags.kind_append;
      eps_pkg::C_NOT_SEARCH:  take = !flags.kind_search;
      eps_pkg::C_EMPTY:       take = flags.empty;
      eps_pkg::C_EQ:          take = flags.eq;
      eps_pkg::C_GT:          take = flags.gt;
      eps_pkg::C_PTR_GE_N:    take = flags.ptr_ge_n;
      eps_pkg::C_PTR_GT_HI:   take = flags.ptr_gt_hi;
      eps_pkg::C_OUT_BUSY:    take = flags.out_busy;
      default:                take = 1'b1;
    endcase
    upc_next = take ? uword.target : upc + eps_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= eps_pkg::S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: src/eps_datapath.sv
// ----------------------------------------------------------------------------
// eps_datapath: element memory, search registers and result register
// Executes the operation named by the current control word and reports the
// compare and bound flags that the sequencer branches on.
// ----------------------------------------------------------------------------
module eps_datapath #(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  eps_pkg::ctrl_t   ctrl,
  output eps_pkg::flags_t  flags,
  input  logic             item_valid,
  output logic             item_stall,
  input  eps_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output eps_pkg::result_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = AW + 1;

  logic [eps_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [eps_pkg::VALUE_W-1:0] rdata;
  logic [eps_pkg::VALUE_W-1:0] key;
  logic [1:0]                  kind;
  logic [IW-1:0]               count;
  logic [IW-1:0]               ptr;
  logic [IW-1:0]               hi;
  logic [eps_pkg::CMP_W-1:0]   cmp;
  logic                        found;
  logic                        accept;
  logic                        out_busy;
  logic                        emit;

  assign item_stall = (ctrl.op != eps_pkg::OP_FETCH);
  assign accept     = item_valid && !item_stall;
  assign out_busy   = result_valid && result_stall;
  assign emit       = (ctrl.op == eps_pkg::OP_EMIT) && !out_busy;

  assign flags.accept      = accept;
  assign flags.kind_clear  = (kind == eps_pkg::KIND_CLEAR);
  assign flags.kind_append = (kind == eps_pkg::KIND_APPEND);
  assign flags.kind_search = (kind == eps_pkg::KIND_SEARCH);
  assign flags.empty       = (count == '0);
  assign flags.eq          = (rdata == key);
  assign flags.gt          = (rdata > key);
  assign flags.ptr_ge_n    = (ptr >= count);
  assign flags.ptr_gt_hi   = (ptr > hi);
  assign flags.out_busy    = out_busy;

  // Element memory: one write port for appends, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.op == eps_pkg::OP_APPEND && count != IW'(DEPTH)) begin
      mem[count[AW-1:0]] <= key;
    end
    if (ctrl.op == eps_pkg::OP_READ) begin
      rdata <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.op == eps_pkg::OP_CLEAR) begin
      count <= '0;
    end else if (ctrl.op == eps_pkg::OP_APPEND && count != IW'(DEPTH)) begin
      count <= count + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      eps_pkg::OP_FETCH: begin
        if (accept) begin
          kind <= item.kind;
          key  <= item.value;
        end
      end
      eps_pkg::OP_START: begin
        ptr   <= '0;
        cmp   <= '0;
        found <= 1'b0;
      end
      eps_pkg::OP_READ: begin
        if (cmp != {eps_pkg::CMP_W{1'b1}}) begin
          cmp <= cmp + eps_pkg::CMP_W'(1);
        end
      end
      eps_pkg::OP_DOUBLE: begin
        ptr <= (ptr == '0) ? IW'(2) : {ptr[IW-2:0], 1'b0};
      end
      eps_pkg::OP_FOUND: begin
        found <= 1'b1;
      end
      eps_pkg::OP_SCAN_GT: begin
        hi  <= ptr;
        ptr <= ptr >> 1;
      end
      eps_pkg::OP_SCAN_END: begin
        hi  <= count - IW'(1);
        ptr <= ptr >> 1;
      end
      eps_pkg::OP_INC: begin
        ptr <= ptr + IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.present     <= found;
      result.comparisons <= cmp;
    end
  end

endmodule

// File: src/exponential_probe_search_core.sv
// ----------------------------------------------------------------------------
// exponential_probe_search_core: exponential search over a loaded array
// Top level joining the microprogram sequencer and the search datapath.
// ----------------------------------------------------------------------------
// Usage: the item channel (item_valid, item_stall, item) carries one word
// per command. Kind clear empties the array, kind append stores one element
// at the end (ignored once DEPTH elements are held), kind search looks up a
// key; the unused kind is dropped. Only a search produces a word on the
// result channel (result_valid, result_stall, result), which gives whether
// the key was found and how many elements were compared, saturating at 255.
// The block takes one command at a time. A search first probes at doubling
// indices and then scans linearly, and every comparison goes through the
// single registered read port of the element memory.
// The result word sits in an output register, so a new command is accepted
// while the receiver stalls the previous result; a later search waits at its
// final step until that register is free. Reset empties the array, drops any
// pending result and returns the sequencer to the fetch step; element
// contents are not cleared and are only read below the fill count.
// ----------------------------------------------------------------------------
module exponential_probe_search_core #(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  eps_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output eps_pkg::result_t result
);

  // Control word from the sequencer and the flags it branches on.
  eps_pkg::ctrl_t  ctrl;
  eps_pkg::flags_t flags;

  eps_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  eps_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .flags        (flags),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for exponential_probe_search_core
// Loads sorted (and sometimes unsorted) arrays through the item channel and
// fires search words at them. A predictor of its own keeps the element array
// and fill count, works out present/comparisons for every accepted search and
// compares each result word with the oldest outstanding answer. Both channels
// idle in random bursts, and the result side is once held off long enough
// for the core to back up into its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH = 128;
  localparam int ITEM_TARGET = 1350;
  // The last stretch of the run goes without any idling.
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [eps_pkg::VALUE_W-1:0] VALUE_MAX = '1;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  eps_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  eps_pkg::result_t result;

  exponential_probe_search_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  // Predicted contents of the core: the loaded elements and their count.
  logic [eps_pkg::VALUE_W-1:0] element_mem [DEPTH];
  int unsigned                 fill_count;
  // Answers of accepted searches whose result word has not arrived yet.
  eps_pkg::result_t            answer_q [$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          long_hold_req;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: exponential search as the core performs it. Probes go to
  // indices 0, 2, 4, 8, ...; a probe equal to the key ends the search, the
  // first probe above the key or running past the fill count starts a linear
  // scan from half the probe index. Each probe and each scanned element is
  // one comparison, and the count saturates at 255.
  // --------------------------------------------------------------------------
  function automatic eps_pkg::result_t search_lookup(
      input logic [eps_pkg::VALUE_W-1:0] key);
    eps_pkg::result_t r;
    int unsigned      pos, probes, cnt, lo, hi, j;
    bit               hit, scan;
    pos = 0;
    probes = 1;
    cnt = 0;
    lo = 0;
    hi = 0;
    hit = 1'b0;
    scan = 1'b0;
    while (pos < fill_count) begin
      if (element_mem[pos] == key) begin
        hit = 1'b1;
        cnt = probes;
        break;
      end
      if (element_mem[pos] > key) begin
        cnt = probes;
        lo = pos / 2;
        hi = pos;
        scan = 1'b1;
        break;
      end
      pos = (pos == 0) ? 2 : pos * 2;
      if (pos >= fill_count) begin
        // Ran past the end: scan from half the new probe index to the last element.
        cnt = probes;
        lo = pos / 2;
        hi = fill_count - 1;
        scan = 1'b1;
        break;
      end
      probes++;
    end
    if (scan) begin
      for (j = lo; j <= hi && j < fill_count; j++) begin
        cnt++;
        if (element_mem[j] == key) begin
          hit = 1'b1;
          break;
        end
      end
    end
    r.present = hit;
    r.comparisons = (cnt > 255) ? 8'd255 : cnt[eps_pkg::CMP_W-1:0];
    return r;
  endfunction

  // Updates the predicted state for one accepted input word.
  task automatic apply_word(input eps_pkg::item_t w);
    case (w.kind)
      eps_pkg::KIND_CLEAR: begin
        fill_count = 0;
      end
      eps_pkg::KIND_APPEND: begin
        // Appends to a full array are dropped by the core.
        if (fill_count < DEPTH) begin
          element_mem[fill_count] = w.value;
          fill_count++;
        end
      end
      eps_pkg::KIND_SEARCH: begin
        answer_q.push_back(search_lookup(w.value));
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input eps_pkg::result_t got);
    eps_pkg::result_t want;
    if (answer_q.size() == 0) begin
      note_mismatch($sformatf("result word with no search pending: present=%0d comparisons=%0d",
                              got.present, got.comparisons));
    end else begin
      want = answer_q.pop_front();
      if (got.present !== want.present)
        note_mismatch($sformatf("present: expected %0d, actual %0d",
                                want.present, got.present));
      if (got.comparisons !== want.comparisons)
        note_mismatch($sformatf("comparisons: expected %0d, actual %0d",
                                want.comparisons, got.comparisons));
    end
  endtask

  // Both channels are sampled at the rising edge; inputs only move at the
  // falling edge, so every value seen here is settled. The watchdog counts
  // edges at which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        apply_word(item);
      if (result_valid && !result_stall)
        check_result(result);
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request so that
  // the core backs up into its item channel.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      result_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 5);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic [eps_pkg::VALUE_W-1:0] rand_value();
    int unsigned raw;
    raw = $urandom();
    return raw[eps_pkg::VALUE_W-1:0];
  endfunction

  // Offers one word and returns at the rising edge that accepts it. Valid
  // stays high into the next call, so words can go back to back.
  task automatic send_word(input logic [1:0] kind,
                           input logic [eps_pkg::VALUE_W-1:0] value);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= '{kind: kind, value: value};
    do @(posedge clk); while (item_stall);
    if (kind != KIND_UNUSED)
      items_sent++;
  endtask

  // Sender pause: nothing offered until every search has been answered.
  task automatic wait_drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Searches on an empty array, the unused kind, and a clear of nothing.
  task automatic test_empty_and_unused();
    send_word(eps_pkg::KIND_SEARCH, '0);
    send_word(eps_pkg::KIND_SEARCH, VALUE_MAX);
    send_word(KIND_UNUSED, '0);
    send_word(KIND_UNUSED, VALUE_MAX);
    send_word(eps_pkg::KIND_CLEAR, VALUE_MAX);
    send_word(eps_pkg::KIND_SEARCH, 31'd5);
  endtask

  // Value extremes in a short sorted array, then an unsorted array where
  // the probe steps over a stored key.
  task automatic test_value_extremes();
    send_word(eps_pkg::KIND_CLEAR, '0);
    send_word(eps_pkg::KIND_APPEND, '0);
    send_word(eps_pkg::KIND_APPEND, 31'd3);
    send_word(eps_pkg::KIND_APPEND, 31'h4000_0000);
    send_word(eps_pkg::KIND_APPEND, VALUE_MAX);
    send_word(eps_pkg::KIND_SEARCH, '0);
    send_word(eps_pkg::KIND_SEARCH, 31'd3);
    send_word(eps_pkg::KIND_SEARCH, VALUE_MAX);
    send_word(eps_pkg::KIND_SEARCH, 31'h2000_0000);
    send_word(eps_pkg::KIND_SEARCH, VALUE_MAX - 31'd1);
    send_word(eps_pkg::KIND_CLEAR, '0);
    send_word(eps_pkg::KIND_APPEND, 31'd9);
    send_word(eps_pkg::KIND_APPEND, 31'd1);
    send_word(eps_pkg::KIND_SEARCH, 31'd1);
  endtask

  // Fills all DEPTH entries, tries to append past the end, and searches
  // keys that end on a probe, in the scan after a larger probe, and in the
  // scan that runs to the last element.
  task automatic test_full_array();
    int unsigned k;
    send_word(eps_pkg::KIND_CLEAR, '0);
    for (k = 0; k < DEPTH; k++)
      send_word(eps_pkg::KIND_APPEND, 31'(k * 3 + 1));
    send_word(eps_pkg::KIND_APPEND, 31'd5);
    send_word(eps_pkg::KIND_APPEND, '0);
    send_word(eps_pkg::KIND_SEARCH, 31'd1);
    send_word(eps_pkg::KIND_SEARCH, 31'(DEPTH * 3 - 2));
    send_word(eps_pkg::KIND_SEARCH, '0);
    send_word(eps_pkg::KIND_SEARCH, 31'(DEPTH * 3));
    send_word(eps_pkg::KIND_SEARCH, 31'd190);
    send_word(eps_pkg::KIND_SEARCH, 31'd193);
    send_word(eps_pkg::KIND_SEARCH, 31'd2);
    send_word(eps_pkg::KIND_SEARCH, VALUE_MAX);
  endtask

  // The result side holds off for a long stretch while quick searches keep
  // coming: the output register fills, the next search parks at its final
  // step, and the item channel has to stall.
  task automatic test_result_backpressure();
    int unsigned k;
    wait_drain();
    long_hold_req = 1'b1;
    for (k = 0; k < 8; k++)
      send_word(eps_pkg::KIND_SEARCH, (k % 2 == 0) ? 31'd1 : 31'd7);
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Random sequences: mostly clear, a sorted load and a batch of searches;
  // some loads are unsorted, some skip the clear and grow the old array, and
  // the unused kind is sprinkled in as noise.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(100, DEPTH + 3);
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  function automatic logic [eps_pkg::VALUE_W-1:0] pick_key(
      ref logic [eps_pkg::VALUE_W-1:0] vals[$]);
    logic [eps_pkg::VALUE_W-1:0] v;
    if (vals.size() == 0)
      return rand_value();
    v = vals[$urandom_range(0, vals.size() - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return v;
      5:             return (v == VALUE_MAX) ? v : v + 31'd1;
      6:             return (v == '0) ? v : v - 31'd1;
      7, 8:          return rand_value();
      default:       return ($urandom_range(0, 1) == 0) ? '0 : VALUE_MAX;
    endcase
  endfunction

  task automatic run_sequence();
    logic [eps_pkg::VALUE_W-1:0] vals [$];
    logic [eps_pkg::VALUE_W-1:0] v;
    longint                      acc, step_max;
    int unsigned                 n, m, k;
    bit                          ordered;
    ordered = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 6) != 0)
      send_word(eps_pkg::KIND_CLEAR, rand_value());
    case ($urandom_range(0, 3))
      0:       step_max = 2;
      1:       step_max = 100;
      2:       step_max = 1 << 20;
      default: step_max = 1 << 25;
    endcase
    acc = ($urandom_range(0, 3) == 0) ? longint'(rand_value()) : $urandom_range(0, 1000);
    n = pick_size();
    for (k = 0; k < n; k++) begin
      if (acc > VALUE_MAX)
        acc = longint'(VALUE_MAX);
      v = ordered ? acc[eps_pkg::VALUE_W-1:0] : rand_value();
      vals.push_back(v);
      send_word(eps_pkg::KIND_APPEND, v);
      acc += $urandom_range(0, int'(step_max));
    end
    m = $urandom_range(2, 10);
    for (k = 0; k < m; k++) begin
      if ($urandom_range(0, 11) == 0)
        send_word(KIND_UNUSED, rand_value());
      send_word(eps_pkg::KIND_SEARCH, pick_key(vals));
    end
  endtask

  task automatic test_random_sequences();
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - QUIET_TAIL)
        idle_on = 1'b0;
      run_sequence();
      if ($urandom_range(0, 4) == 0)
        wait_drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    fill_count = 0;
    mismatches = 0;
    items_sent = 0;
    quiet_cycles = 0;
    hold_left = 0;
    long_hold_req = 1'b0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_unused();
    test_value_extremes();
    test_full_array();
    test_result_backpressure();
    test_random_sequences();

    // Let the last words settle; appends and clears give no result, so
    // wait a little past the final answer before judging.
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0)
      note_mismatch($sformatf("%0d searches never answered", answer_q.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
src/eps_pkg.sv
src/eps_sequencer.sv
src/eps_datapath.sv
src/exponential_probe_search_core.sv
bench/testbench.sv
